/* rtl/sfrc_pkg.sv */
// Shared types, codes and the CRC-16 byte update for the serial frame receiver.
`default_nettype none

package sfrc_pkg;

    // Register reset values and widths
    localparam int unsigned REG_W           = 16;
    localparam logic [REG_W-1:0] MAX_LEN_RST = 16'd256;
    localparam logic [REG_W-1:0] TIMEOUT_RST = 16'd100;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes
    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    // Frame marker bytes and CRC polynomial
    localparam logic [7:0]  START_SHORT = 8'h02;
    localparam logic [7:0]  START_LONG  = 8'h03;
    localparam logic [7:0]  END_MARK    = 8'h03;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes
    localparam logic [2:0] VERDICT_GOOD    = 3'd0;
    localparam logic [2:0] VERDICT_CRC     = 3'd1;
    localparam logic [2:0] VERDICT_END     = 3'd2;
    localparam logic [2:0] VERDICT_LENGTH  = 3'd3;
    localparam logic [2:0] VERDICT_TIMEOUT = 3'd4;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic       is_tick;
        logic       is_start_short;
        logic       is_start_long;
        logic       is_end_mark;
        logic [7:0] data;
    } op_t;

    // One result item
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  verdict;
        logic [15:0] frame_length;
    } res_t;

    // CRC-16/XMODEM update over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/sfrc_if.sv */
// Valid/ready channel interfaces for received requests and result items.
`default_nettype none

interface sfrc_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface sfrc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  verdict;
    logic [15:0] frame_length;

    modport source (output valid, output result_kind, output payload_byte,
                    output verdict, output frame_length, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input verdict, input frame_length, output ready);
endinterface

`default_nettype wire

/* rtl/sfrc_front.sv */
// Front stage: accept requests, classify them and register them for the queue.
`default_nettype none

module sfrc_front
    import sfrc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfrc_in_if.sink    rx,
    output op_t        op,
    output logic       op_valid,
    input  wire logic  op_ready
);

    logic valid_reg;
    logic valid_next;
    op_t  op_reg;
    op_t  op_next;
    logic take;

    // Accept whenever the holding register is empty or drains this cycle
    assign rx.ready = !valid_reg || op_ready;
    assign take     = rx.valid && rx.ready;

    // Classify the incoming request
    always_comb
    begin
        op_next                = op_reg;
        valid_next             = valid_reg;
        if (op_ready)
            valid_next = 1'b0;
        if (take)
        begin
            valid_next             = 1'b1;
            op_next.is_tick        = (rx.cmd == CMD_TICK);
            op_next.is_start_short = (rx.cmd == CMD_BYTE) && (rx.rx_byte == START_SHORT);
            op_next.is_start_long  = (rx.cmd == CMD_BYTE) && (rx.rx_byte == START_LONG);
            op_next.is_end_mark    = (rx.cmd == CMD_BYTE) && (rx.rx_byte == END_MARK);
            op_next.data           = rx.rx_byte;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load the classified request
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign op       = op_reg;
    assign op_valid = valid_reg;

endmodule

`default_nettype wire

/* rtl/sfrc_queue.sv */
// Short FIFO of classified requests between the front and the back.
`default_nettype none

module sfrc_queue
    import sfrc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire op_t   push_op,
    input  wire logic  push_valid,
    output logic       push_ready,
    output op_t        pop_op,
    output logic       pop_valid,
    input  wire logic  pop_ready
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    op_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == PTR_W'(DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == PTR_W'(DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

/* rtl/sfrc_back.sv */
// Back stage: frame state machine, CRC check, timeout and result register.
`default_nettype none

module sfrc_back
    import sfrc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    input  wire op_t              op,
    input  wire logic             op_valid,
    output logic                  op_ready,
    sfrc_out_if.source            res
);

    // Frame phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC_HI  = 3'd4;
    localparam logic [2:0] PH_CRC_LO  = 3'd5;
    localparam logic [2:0] PH_END     = 3'd6;

    localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

    logic [REG_W-1:0] max_len_reg;
    logic [REG_W-1:0] timeout_reg;
    logic [2:0]       phase_reg,    phase_next;
    logic [15:0]      length_reg,   length_next;
    logic [15:0]      seen_reg,     seen_next;
    logic [15:0]      crc_reg,      crc_next;
    logic [15:0]      rx_crc_reg,   rx_crc_next;
    logic [16:0]      idle_reg,     idle_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg,      res_next;

    logic             pop;
    logic [16:0]      idle_inc;
    logic [15:0]      len_full;
    logic [15:0]      seen_inc;

    // Take the next request when the result register is free or drains now
    assign op_ready = !res_valid_reg || res.ready;
    assign pop      = op_valid && op_ready;

    assign idle_inc = (idle_reg < IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;
    assign len_full = {length_reg[15:8], op.data};
    assign seen_inc = seen_reg + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        seen_next      = seen_reg;
        crc_next       = crc_reg;
        rx_crc_next    = rx_crc_reg;
        idle_next      = idle_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res.ready)
            res_valid_next = 1'b0;

        if (pop)
        begin
            if (op.is_tick)
            begin
                // Count idle ticks mid-frame, abort past the limit
                if (phase_reg != PH_IDLE)
                begin
                    if (idle_inc > {1'b0, timeout_reg})
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{KIND_VERDICT, 8'h00, VERDICT_TIMEOUT, length_reg};
                        phase_next     = PH_IDLE;
                        idle_next      = '0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            else
            begin
                if (phase_reg != PH_IDLE)
                    idle_next = '0;
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (op.is_start_short)
                        begin
                            length_next = '0;
                            idle_next   = '0;
                            phase_next  = PH_LEN_LO;
                        end
                        else if (op.is_start_long)
                        begin
                            length_next = '0;
                            idle_next   = '0;
                            phase_next  = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        length_next = {op.data, 8'h00};
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        length_next = len_full;
                        if (len_full == '0 || len_full > max_len_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = '{KIND_VERDICT, 8'h00, VERDICT_LENGTH, len_full};
                            phase_next     = PH_IDLE;
                            idle_next      = '0;
                        end
                        else
                        begin
                            seen_next  = '0;
                            crc_next   = '0;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        // Emit the byte and fold it into the CRC
                        crc_next       = crc_byte(crc_reg, op.data);
                        seen_next      = seen_inc;
                        if (seen_inc == length_reg)
                            phase_next = PH_CRC_HI;
                        res_valid_next = 1'b1;
                        res_next       = '{KIND_PAYLOAD, op.data, VERDICT_GOOD, 16'h0000};
                    end
                    PH_CRC_HI:
                    begin
                        rx_crc_next = {op.data, 8'h00};
                        phase_next  = PH_CRC_LO;
                    end
                    PH_CRC_LO:
                    begin
                        rx_crc_next = {rx_crc_reg[15:8], op.data};
                        phase_next  = PH_END;
                    end
                    PH_END:
                    begin
                        res_valid_next = 1'b1;
                        phase_next     = PH_IDLE;
                        idle_next      = '0;
                        if (!op.is_end_mark)
                            res_next = '{KIND_VERDICT, 8'h00, VERDICT_END, length_reg};
                        else if (crc_reg != rx_crc_reg)
                            res_next = '{KIND_VERDICT, 8'h00, VERDICT_CRC, length_reg};
                        else
                            res_next = '{KIND_VERDICT, 8'h00, VERDICT_GOOD, length_reg};
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        idle_next  = '0;
                    end
                endcase
            end
        end
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RST;
            timeout_reg   <= TIMEOUT_RST;
            phase_reg     <= PH_IDLE;
            length_reg    <= '0;
            seen_reg      <= '0;
            crc_reg       <= '0;
            rx_crc_reg    <= '0;
            idle_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_MAX_LEN)
                max_len_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_TIMEOUT)
                timeout_reg <= cfg_data;
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            seen_reg      <= seen_next;
            crc_reg       <= crc_next;
            rx_crc_reg    <= rx_crc_next;
            idle_reg      <= idle_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res.valid        = res_valid_reg;
    assign res.result_kind  = res_reg.result_kind;
    assign res.payload_byte = res_reg.payload_byte;
    assign res.verdict      = res_reg.verdict;
    assign res.frame_length = res_reg.frame_length;

endmodule

`default_nettype wire

/* rtl/serial_frame_receiver_crc16.sv */
// Top level of the length-prefixed serial frame receiver with CRC-16 check.
//
//  channel      dir  handshake       payload
//  rx_chan      in   valid/ready     cmd, rx_byte
//  result_chan  out  valid/ready     result_kind, payload_byte, verdict, frame_length
//  cfg          in   cfg_we          cfg_index, cfg_data
//
// One request per cycle is taken while the front register or the queue has room;
// an accepted request passes the front register and the queue to the frame state
// machine, which places any result it produces in the result register.
// The CRC-16 update of a byte is computed combinationally in the back stage.
// Reset clears the frame state and loads the register defaults.
// A stalled result holds the back; the queue and front keep accepting until full.
`default_nettype none

module serial_frame_receiver_crc16
    import sfrc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    sfrc_in_if.sink               rx_chan,
    sfrc_out_if.source            result_chan
);

    op_t  front_op;
    logic front_valid;
    logic front_ready;
    op_t  queue_op;
    logic queue_valid;
    logic queue_ready;

    sfrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx_chan),
        .op       (front_op),
        .op_valid (front_valid),
        .op_ready (front_ready)
    );

    sfrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (front_op),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_op     (queue_op),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    sfrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (queue_op),
        .op_valid  (queue_valid),
        .op_ready  (queue_ready),
        .res       (result_chan)
    );

endmodule

`default_nettype wire

/* verif/sfrc_frame_checker.sv */
// Checker: watches the request and result channels, predicts results, counts mismatches.
`timescale 1ns / 1ps

module sfrc_frame_checker
    import sfrc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    sfrc_in_if                    rx_chan,
    sfrc_out_if                   result_chan,
    output int unsigned           fail_count,
    output int unsigned           results_due
);

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_LEN_HI,
        RX_LEN_LO,
        RX_PAYLOAD,
        RX_CRC_HI,
        RX_CRC_LO,
        RX_END
    } rx_phase_e;

    localparam logic [16:0] TICKS_SAT = 17'h1FFFF;

    // Predicted receiver state and register copies
    rx_phase_e   rx_phase;
    logic [15:0] len_limit;
    logic [15:0] tick_limit;
    logic [15:0] hdr_len;
    logic [15:0] payload_count;
    logic [15:0] crc_acc;
    logic [15:0] crc_sent;
    logic [16:0] quiet_ticks;

    // Results owed by the block, oldest first
    res_t        owed_results [$];
    res_t        oldest;

    // CRC-16/XMODEM, one message bit at a time, MSB first
    function automatic logic [15:0] crc16_xmodem(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // Close the frame with a verdict and go back to hunting for a start byte
    function automatic void close_frame(input logic [2:0] code);
        res_t r;
        r.result_kind  = KIND_VERDICT;
        r.payload_byte = 8'h00;
        r.verdict      = code;
        r.frame_length = hdr_len;
        owed_results.push_back(r);
        rx_phase    = RX_IDLE;
        quiet_ticks = '0;
    endfunction

    // Advance the predicted receiver by one accepted request
    function automatic void deframe_request(input logic c, input logic [7:0] b);
        res_t r;
        if (c == CMD_TICK)
        begin
            if (rx_phase == RX_IDLE)
                return;
            if (quiet_ticks != TICKS_SAT)
                quiet_ticks = quiet_ticks + 17'd1;
            if (quiet_ticks > {1'b0, tick_limit})
                close_frame(VERDICT_TIMEOUT);
            return;
        end

        if (rx_phase != RX_IDLE)
            quiet_ticks = '0;

        case (rx_phase)
            RX_IDLE:
            begin
                if (b == START_SHORT)
                begin
                    hdr_len  = '0;
                    rx_phase = RX_LEN_LO;
                end
                else if (b == START_LONG)
                begin
                    hdr_len  = '0;
                    rx_phase = RX_LEN_HI;
                end
            end
            RX_LEN_HI:
            begin
                hdr_len  = {b, 8'h00};
                rx_phase = RX_LEN_LO;
            end
            RX_LEN_LO:
            begin
                hdr_len = hdr_len | {8'h00, b};
                if (hdr_len == 16'd0 || hdr_len > len_limit)
                    close_frame(VERDICT_LENGTH);
                else
                begin
                    payload_count = '0;
                    crc_acc       = '0;
                    rx_phase      = RX_PAYLOAD;
                end
            end
            RX_PAYLOAD:
            begin
                crc_acc       = crc16_xmodem(crc_acc, b);
                payload_count = payload_count + 16'd1;
                if (payload_count == hdr_len)
                    rx_phase = RX_CRC_HI;
                r.result_kind  = KIND_PAYLOAD;
                r.payload_byte = b;
                r.verdict      = VERDICT_GOOD;
                r.frame_length = '0;
                owed_results.push_back(r);
            end
            RX_CRC_HI:
            begin
                crc_sent = {b, 8'h00};
                rx_phase = RX_CRC_LO;
            end
            RX_CRC_LO:
            begin
                crc_sent[7:0] = b;
                rx_phase      = RX_END;
            end
            RX_END:
            begin
                if (b != END_MARK)
                    close_frame(VERDICT_END);
                else if (crc_acc != crc_sent)
                    close_frame(VERDICT_CRC);
                else
                    close_frame(VERDICT_GOOD);
            end
            default:
            begin
                rx_phase    = RX_IDLE;
                quiet_ticks = '0;
            end
        endcase
    endfunction

    // Report one field that differs from the prediction
    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // Track register writes, predict on requests, compare on results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_limit     = MAX_LEN_RST;
            tick_limit    = TIMEOUT_RST;
            rx_phase      = RX_IDLE;
            hdr_len       = '0;
            payload_count = '0;
            crc_acc       = '0;
            crc_sent      = '0;
            quiet_ticks   = '0;
            fail_count    = 0;
            owed_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_LEN)
                    len_limit = cfg_data;
                else
                    tick_limit = cfg_data;
            end

            if (rx_chan.valid && rx_chan.ready)
                deframe_request(rx_chan.cmd, rx_chan.rx_byte);

            if (result_chan.valid && result_chan.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with none expected: kind %0d byte %h verdict %0d len %h",
                             $time, result_chan.result_kind, result_chan.payload_byte,
                             result_chan.verdict, result_chan.frame_length);
                    fail_count++;
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    check_field("result_kind", oldest.result_kind, result_chan.result_kind);
                    check_field("payload_byte", oldest.payload_byte, result_chan.payload_byte);
                    check_field("verdict", oldest.verdict, result_chan.verdict);
                    check_field("frame_length", oldest.frame_length, result_chan.frame_length);
                end
            end
        end
        results_due = owed_results.size();
    end

endmodule

/* verif/tb_serial_frame_receiver_crc16.sv */
// Testbench top: clock, reset, register writes, frame stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_serial_frame_receiver_crc16;
    import sfrc_pkg::*;

    localparam int          HOLD_OFF_CYCLES = 150;
    localparam int unsigned RANDOM_ITEMS    = 1450;
    localparam int unsigned PHASE_ITEMS     = 150;

    typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_END, FR_CUT} frame_fault_e;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [REG_W-1:0] cfg_data;
    int unsigned      fail_count;
    int unsigned      results_due;

    bit               quiet;
    bit               hold_off_go;
    logic [15:0]      cur_max;
    logic [15:0]      cur_timeout;
    int unsigned      req_count;
    int               tick_pct;

    sfrc_in_if  rx_chan ();
    sfrc_out_if result_chan ();

    serial_frame_receiver_crc16 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_chan     (rx_chan),
        .result_chan (result_chan)
    );

    sfrc_frame_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_chan     (rx_chan),
        .result_chan (result_chan),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always #5 clk = ~clk;

    // Watchdog: abort a hung run
    initial
    begin
        #10_000_000;
        $display("tb_serial_frame_receiver_crc16 NOT OK");
        $finish;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // CRC-16/XMODEM of the payload, for building well-formed frames
    function automatic logic [15:0] frame_crc(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // Offer one request after a random gap; return at the falling edge after acceptance
    task automatic send_req(input logic c, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_chan.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.cmd     <= c;
        rx_chan.rx_byte <= b;
        @(posedge clk);
        while (!rx_chan.ready)
            @(posedge clk);
        @(negedge clk);
        req_count++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_req(CMD_TICK, 8'($urandom));
    endtask

    // Build a frame with random payload, apply the fault, send it with sparse ticks
    task automatic send_frame(input bit long_hdr, input logic [15:0] len,
                              input frame_fault_e fault);
        logic [7:0]  seq [$];
        logic [15:0] crc;
        logic [7:0]  b;
        int          cut_at;
        seq.push_back(long_hdr ? START_LONG : START_SHORT);
        if (long_hdr)
            seq.push_back(len[15:8]);
        seq.push_back(len[7:0]);
        if (len != 16'd0 && len <= cur_max)
        begin
            crc = '0;
            for (int i = 0; i < int'(len); i++)
            begin
                b = 8'($urandom);
                seq.push_back(b);
                crc = frame_crc(crc, b);
            end
            // A bad end byte wins whatever the CRC, so corrupt that sometimes too
            if (fault == FR_BAD_CRC || (fault == FR_BAD_END && $urandom_range(0, 1) == 1))
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            seq.push_back(crc[15:8]);
            seq.push_back(crc[7:0]);
            if (fault == FR_BAD_END)
            begin
                do
                    b = 8'($urandom);
                while (b == END_MARK);
                seq.push_back(b);
            end
            else
                seq.push_back(END_MARK);
        end

        cut_at = (fault == FR_CUT) ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int i = 0; i < cut_at; i++)
        begin
            // Ticks between bytes stay within the limit, so the frame survives
            if (i > 0 && cur_timeout > 0 && $urandom_range(0, 99) < tick_pct)
                send_ticks($urandom_range(1, (cur_timeout < 3) ? cur_timeout : 3));
            send_req(CMD_BYTE, seq[i]);
        end
        if (fault == FR_CUT)
            send_ticks(int'(cur_timeout) + 1);
    endtask

    // Write a register once every owed result is out and the pipeline has drained
    task automatic write_reg(input logic idx, input logic [15:0] val);
        rx_chan.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_LEN)
            cur_max = val;
        else
            cur_timeout = val;
    endtask

    // Result ready: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left        = 0;
        result_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                stall_left  = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                result_chan.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_chan.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned  base;
        int unsigned  stop;
        int           p;
        int           r;
        logic [15:0]  max_set;
        logic [15:0]  to_set;
        logic [15:0]  len;
        logic [7:0]   b;
        frame_fault_e fault;

        rst_n           = 1'b0;
        rx_chan.valid   = 1'b0;
        rx_chan.cmd     = CMD_BYTE;
        rx_chan.rx_byte = 8'h00;
        cfg_we          = 1'b0;
        cfg_index       = CFG_MAX_LEN;
        cfg_data        = '0;
        quiet           = 1'b0;
        hold_off_go     = 1'b0;
        cur_max         = MAX_LEN_RST;
        cur_timeout     = TIMEOUT_RST;
        tick_pct        = 0;
        req_count       = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle noise, extreme lengths, the good, length, CRC and end verdicts
        send_req(CMD_BYTE, 8'hFF);
        send_req(CMD_TICK, 8'h00);
        send_frame(1'b0, 16'd1, FR_GOOD);
        send_frame(1'b1, 16'd0, FR_GOOD);
        send_frame(1'b1, 16'hFFFF, FR_GOOD);
        send_frame(1'b0, 16'd2, FR_BAD_CRC);
        send_frame(1'b0, 16'd1, FR_BAD_END);

        // Zero tick limit: the first mid-frame tick aborts, also inside the header
        write_reg(CFG_TIMEOUT, 16'd0);
        send_req(CMD_BYTE, START_SHORT);
        send_req(CMD_TICK, 8'h00);
        send_req(CMD_BYTE, START_LONG);
        send_req(CMD_BYTE, 8'hA5);
        send_req(CMD_TICK, 8'hFF);

        // Random frames across a plan of register settings
        base = req_count;
        p    = 0;
        while (req_count - base < RANDOM_ITEMS)
        begin
            case (p % 7)
                0: begin max_set = 16'd256;   to_set = 16'd100;   end
                1: begin max_set = 16'd1;     to_set = 16'd0;     end
                2: begin max_set = 16'hFFFF;  to_set = 16'hFFFF;  end
                3: begin max_set = 16'd8;     to_set = 16'd3;     end
                4: begin max_set = 16'd0;     to_set = 16'd2;     end
                5: begin max_set = 16'd300;   to_set = 16'd5;     end
                default: begin max_set = 16'd40; to_set = 16'd1;  end
            endcase
            write_reg(CFG_MAX_LEN, max_set);
            write_reg(CFG_TIMEOUT, to_set);
            quiet    = (p % 7 == 3);
            tick_pct = $urandom_range(0, 15);

            // Long receiver hold-off while a frame streams in
            if (p == 0)
            begin
                hold_off_go = 1'b1;
                send_frame(1'b0, 16'd24, FR_GOOD);
            end
            // A few frames beyond one length byte
            if (p < 7 && cur_max >= 16'd270)
                send_frame(1'b1, 16'($urandom_range(256, 270)), FR_GOOD);

            // Stop the last phase at the overall item budget
            stop = req_count + PHASE_ITEMS;
            if (stop > base + RANDOM_ITEMS)
                stop = base + RANDOM_ITEMS;
            while (req_count < stop)
            begin
                if ($urandom_range(0, 199) == 0)
                    hold_off_go = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    // Idle noise: bytes that open no frame, and idle ticks
                    do
                        b = 8'($urandom);
                    while (b == START_SHORT || b == START_LONG);
                    if ($urandom_range(0, 1) == 1)
                        send_req(CMD_BYTE, b);
                    else
                        send_req(CMD_TICK, b);
                end
                else
                begin
                    r     = $urandom_range(0, 99);
                    fault = FR_GOOD;
                    if (r < 15)
                        fault = FR_BAD_CRC;
                    else if (r < 25)
                        fault = FR_BAD_END;
                    else if (r < 35 && cur_timeout <= 16'd8)
                        fault = FR_CUT;

                    r = $urandom_range(0, 99);
                    if (cur_max == 16'd0)
                        len = 16'($urandom);
                    else if (r < 10)
                        len = (cur_max == 16'hFFFF || $urandom_range(0, 1) == 1) ?
                              16'd0 : cur_max + 16'd1;
                    else
                        len = 16'($urandom_range(1, (cur_max < 16'd12) ? cur_max : 12));
                    send_frame(len > 16'd255 || $urandom_range(0, 1) == 1, len, fault);
                end
            end
            p++;
        end

        // Drain: wait for every owed result, then let the pipeline settle
        rx_chan.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("tb_serial_frame_receiver_crc16 OK");
        else
            $display("tb_serial_frame_receiver_crc16 NOT OK");
        $finish;
    end

endmodule
